>>> src/lsp_pkg.sv
// Shared constants and beat types for the looping sample player.
package lsp_pkg;

  localparam int FRAME_BITS  = 14;
  localparam int FCNT_BITS   = 15;
  localparam int MAX_FRAMES  = 16384;
  localparam int CHANNELS    = 2;
  localparam int CH_BITS     = 1;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int RATE_BITS   = FRAC_BITS + 8;
  localparam int POS_BITS    = 34;
  localparam int MUL_BITS    = 24;
  localparam int MODE_BITS   = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 15;
  localparam int MEM_WORDS   = MAX_FRAMES * CHANNELS;
  localparam int ADDR_BITS   = FRAME_BITS + CH_BITS;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP_START = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP_END   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_POS  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERP     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAMES     = 3'd4;

  // Interpolation modes
  localparam logic [MODE_BITS-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_LINEAR = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CUBIC  = 2'd2;

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic [FRAME_BITS-1:0]         write_frame;
    logic [CH_BITS-1:0]            write_channel;
    logic signed [SAMPLE_BITS-1:0] write_value;
    logic signed [RATE_BITS-1:0]   rate;
    logic                          gate;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [CH_BITS-1:0]            channel;
    logic                          last;
    logic                          done_res;
  } out_beat_t;

endpackage

>>> src/lsp_ram.sv
// Generic single-port RAM with registered read.
module lsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/lsp_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
module lsp_rem #(
  parameter int DW = 17,
  parameter int VW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;

  assign trial = {rem, dvd[DW-1]};

  // Shift in one bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= CW'(DW);
      end else if (busy) begin
        dvd <= dvd << 1;
        if (trial >= {1'b0, dvs}) begin
          rem <= VW'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[VW-1:0];
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/loop_sample_player_interp.sv
// A write beat is taken while idle; a tick runs setup and the bound check, then per
// channel four memory reads and up to three multiply-round passes on one multiplier,
// with the remainder unit run before the clamp when the loop wrap needs it.
// Writes are taken one per cycle while idle; new beats stall until both channel beats of a tick are emitted.
// Reset: position at start frame, gate, play-through and done cleared; memory is
// undefined until written.
module loop_sample_player_interp
  import lsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_beat_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_beat_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int DW = POS_BITS - 1 - FRAC_BITS;
  localparam int PW = MUL_BITS + FRAC_BITS + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_BOUND, ST_DIV, ST_CLAMP, ST_READ,
    ST_COEF, ST_MUL, ST_ACC, ST_FIN, ST_EMIT
  } state_t;

  state_t state;

  // Configuration
  logic [FRAME_BITS-1:0] loop_start, loop_end, start_position;
  logic [MODE_BITS-1:0]  interp_mode;
  logic [FCNT_BITS-1:0]  frames_in_use;

  // Play state
  logic signed [POS_BITS-1:0]  pos;
  logic                        prev_gate, play_through, done_flag;
  logic signed [RATE_BITS-1:0] rate;
  logic                        gate;
  logic [FCNT_BITS-1:0]        fl;
  logic [FRAME_BITS-1:0]       s_r, e_r;
  logic                        fwd;
  logic [FRAC_BITS-1:0]        div_frac;

  // Read and arithmetic
  logic [FRAME_BITS-1:0]         fr0, fr1, fr2, fr3;
  logic [FRAC_BITS-1:0]          frac;
  logic [CH_BITS-1:0]            ch;
  logic [2:0]                    rd_cnt;
  logic signed [SAMPLE_BITS-1:0] y0, y1, y2, y3;
  logic signed [MUL_BITS-1:0]    c1, c2, mul_a, t_acc;
  logic signed [PW-1:0]          prod;
  logic [1:0]                    step;
  logic signed [SAMPLE_BITS-1:0] v_sat;

  // Setup bounds from the registers
  logic [FCNT_BITS-1:0]  f_c;
  logic [FRAME_BITS-1:0] lastf, sa, ea, s_c, e_c, sp_c;

  always_comb begin
    if (frames_in_use < FCNT_BITS'(2)) f_c = FCNT_BITS'(2);
    else if (frames_in_use > FCNT_BITS'(MAX_FRAMES)) f_c = FCNT_BITS'(MAX_FRAMES);
    else f_c = frames_in_use;
    lastf = FRAME_BITS'(f_c - 1'b1);
    sa = (loop_start < lastf) ? loop_start : lastf;
    ea = (loop_end < lastf) ? loop_end : lastf;
    s_c = (sa > ea) ? ea : sa;
    e_c = (sa > ea) ? sa : ea;
    if (s_c == e_c) begin
      if (e_c >= lastf) s_c = e_c - 1'b1;
      else e_c = s_c + 1'b1;
    end
    sp_c = (start_position > lastf) ? lastf : start_position;
  end

  // Wrap compare against the loop bounds
  logic signed [POS_BITS-1:0] lo, hi, len, hi_x, lo_x, pm, pp;
  logic [POS_BITS-1:0] dvd_full;
  logic                div_start;

  always_comb begin
    lo  = POS_BITS'({s_r, {FRAC_BITS{1'b0}}});
    hi  = POS_BITS'({e_r, {FRAC_BITS{1'b0}}});
    len = hi - lo;
    hi_x = play_through ? POS_BITS'({fl, {FRAC_BITS{1'b0}}}) : hi;
    lo_x = play_through ? '0 : lo;
    pm = pos - len;
    pp = pos + len;
    dvd_full = fwd ? POS_BITS'(pm - lo) : POS_BITS'(hi - pp);
    div_start = 1'b0;
    if (state == ST_BOUND && !play_through) begin
      if (fwd && pos > hi_x && pm > hi_x) div_start = 1'b1;
      if (!fwd && pos < lo_x && pp < lo_x) div_start = 1'b1;
    end
  end

  logic                  rem_done;
  logic [FRAME_BITS-1:0] rem_int;
  logic signed [POS_BITS-1:0] rem_full;

  lsp_rem #(.DW(DW), .VW(FRAME_BITS)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_full[POS_BITS-2:FRAC_BITS]),
    .divisor  (e_r - s_r),
    .done     (rem_done),
    .rem      (rem_int)
  );

  assign rem_full = POS_BITS'({rem_int, div_frac});

  // Read position, frame and neighbors
  logic signed [POS_BITS-1:0] r_c, rmax;
  logic [FRAME_BITS-1:0]      i_c;
  logic [FCNT_BITS-1:0]       i_p1, i_p2;

  always_comb begin
    rmax = POS_BITS'({fl - 1'b1, {FRAC_BITS{1'b0}}});
    r_c = pos;
    if (pos < 0) r_c = '0;
    if (pos > rmax) r_c = rmax;
    i_c  = r_c[FRAME_BITS+FRAC_BITS-1:FRAC_BITS];
    i_p1 = FCNT_BITS'(i_c) + 1'b1;
    i_p2 = FCNT_BITS'(i_c) + FCNT_BITS'(2);
  end

  // Memory port: writes from the input, reads from the sequencer
  logic                   ram_we;
  logic [ADDR_BITS-1:0]   ram_addr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [FRAME_BITS-1:0]  rd_frame;

  assign in_stall = (state != ST_IDLE);
  assign ram_we = in_valid && !in_stall && (in_data.cmd == CMD_WRITE);

  always_comb begin
    case (rd_cnt[1:0])
      2'd0:    rd_frame = fr1;
      2'd1:    rd_frame = fr0;
      2'd2:    rd_frame = fr2;
      default: rd_frame = fr3;
    endcase
    ram_addr = ram_we ? {in_data.write_frame, in_data.write_channel} : {rd_frame, ch};
  end

  lsp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MEM_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data.write_value),
    .rdata (ram_rdata)
  );

  // Multiply-round and final value
  logic signed [PW-1:0]          rsum;
  logic signed [MUL_BITS-1:0]    rnd, addend;
  logic signed [MUL_BITS+1:0]    v_full;

  always_comb begin
    rsum = prod + PW'(1 << (FRAC_BITS - 1));
    rnd  = rsum[MUL_BITS+FRAC_BITS-1:FRAC_BITS];
    case (step)
      2'd0:    addend = (interp_mode == MODE_CUBIC) ? c2 : '0;
      2'd1:    addend = c1;
      default: addend = '0;
    endcase
    if (interp_mode == MODE_CUBIC) begin
      v_full = (MUL_BITS+2)'(y1)
               + (((MUL_BITS+2)'(t_acc) + (MUL_BITS+2)'(1)) >>> 1);
    end else if (interp_mode == MODE_LINEAR) begin
      v_full = (MUL_BITS+2)'(y1) + (MUL_BITS+2)'(t_acc);
    end else begin
      v_full = (MUL_BITS+2)'(y1);
    end
    if (v_full > (MUL_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1)) begin
      v_sat = SAMPLE_BITS'((1 << (SAMPLE_BITS-1)) - 1);
    end else if (v_full < -(MUL_BITS+2)'(1 << (SAMPLE_BITS-1))) begin
      v_sat = SAMPLE_BITS'(1 << (SAMPLE_BITS-1));
    end else begin
      v_sat = v_full[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      loop_start    <= '0;
      loop_end      <= FRAME_BITS'(MAX_FRAMES - 1);
      start_position <= '0;
      interp_mode   <= MODE_NONE;
      frames_in_use <= FCNT_BITS'(MAX_FRAMES);
      pos           <= '0;
      prev_gate     <= 1'b0;
      play_through  <= 1'b0;
      done_flag     <= 1'b0;
      out_valid     <= 1'b0;
      ch            <= '0;
      rd_cnt        <= '0;
      step          <= '0;
    end else begin
      // Drop the output beat once taken, unless a new one replaces it
      if (out_valid && !out_stall && state != ST_EMIT) out_valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOOP_START: loop_start     <= cfg_data[FRAME_BITS-1:0];
          CFG_LOOP_END:   loop_end       <= cfg_data[FRAME_BITS-1:0];
          CFG_START_POS:  start_position <= cfg_data[FRAME_BITS-1:0];
          CFG_INTERP:     interp_mode    <= cfg_data[MODE_BITS-1:0];
          CFG_FRAMES:     frames_in_use  <= cfg_data[FCNT_BITS-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_data.cmd == CMD_TICK) begin
            rate  <= in_data.rate;
            gate  <= in_data.gate;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          fl  <= f_c;
          s_r <= s_c;
          e_r <= e_c;
          fwd <= !rate[RATE_BITS-1];
          if (gate && !prev_gate) begin
            done_flag    <= 1'b0;
            play_through <= 1'b0;
            pos          <= POS_BITS'({sp_c, {FRAC_BITS{1'b0}}});
          end else if (!gate && prev_gate) begin
            play_through <= 1'b1;
          end
          prev_gate <= gate;
          state     <= ST_BOUND;
        end
        ST_BOUND: begin
          div_frac <= dvd_full[FRAC_BITS-1:0];
          state    <= ST_CLAMP;
          if (fwd && pos > hi_x) begin
            if (play_through) begin
              done_flag <= 1'b1;
              pos       <= hi_x;
            end else if (pm > hi_x) begin
              state <= ST_DIV;
            end else begin
              pos <= pm;
            end
          end else if (!fwd && pos < lo_x) begin
            if (play_through) begin
              done_flag <= 1'b1;
              pos       <= lo_x;
            end else if (pp < lo_x) begin
              state <= ST_DIV;
            end else begin
              pos <= pp;
            end
          end
        end
        ST_DIV: begin
          if (rem_done) begin
            pos   <= fwd ? lo + rem_full : hi - rem_full;
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          frac   <= r_c[FRAC_BITS-1:0];
          fr1    <= i_c;
          fr2    <= (i_p1 == fl) ? '0 : i_p1[FRAME_BITS-1:0];
          fr0    <= (i_c == '0) ? FRAME_BITS'(fl - 1'b1) : i_c - 1'b1;
          fr3    <= (i_p2 >= fl) ? FRAME_BITS'(i_p2 - fl) : i_p2[FRAME_BITS-1:0];
          ch     <= '0;
          rd_cnt <= '0;
          state  <= ST_READ;
        end
        ST_READ: begin
          // Issue four reads, capture each in the cycle after it is issued
          case (rd_cnt)
            3'd1:    y1 <= ram_rdata;
            3'd2:    y0 <= ram_rdata;
            3'd3:    y2 <= ram_rdata;
            3'd4:    y3 <= ram_rdata;
            default: ;
          endcase
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == 3'd4) state <= ST_COEF;
        end
        ST_COEF: begin
          c1 <= MUL_BITS'(y2) - MUL_BITS'(y0);
          c2 <= (MUL_BITS'(y0) <<< 1) - MUL_BITS'(y1) * MUL_BITS'(5)
                + (MUL_BITS'(y2) <<< 2) - MUL_BITS'(y3);
          step <= '0;
          if (interp_mode == MODE_CUBIC) begin
            mul_a <= MUL_BITS'(y3) - MUL_BITS'(y0)
                     + (MUL_BITS'(y1) - MUL_BITS'(y2)) * MUL_BITS'(3);
            state <= ST_MUL;
          end else if (interp_mode == MODE_LINEAR) begin
            mul_a <= MUL_BITS'(y2) - MUL_BITS'(y1);
            state <= ST_MUL;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_MUL: begin
          prod  <= mul_a * $signed({1'b0, frac});
          state <= ST_ACC;
        end
        ST_ACC: begin
          t_acc <= rnd + addend;
          mul_a <= rnd + addend;
          step  <= step + 1'b1;
          if (interp_mode == MODE_CUBIC && step != 2'd2) state <= ST_MUL;
          else state <= ST_FIN;
        end
        ST_FIN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            out_data.sample_out <= v_sat;
            out_data.channel    <= ch;
            out_data.last       <= (ch == CH_BITS'(CHANNELS - 1));
            out_data.done_res   <= done_flag;
            if (ch == CH_BITS'(CHANNELS - 1)) begin
              pos   <= pos + POS_BITS'(rate);
              state <= ST_IDLE;
            end else begin
              ch     <= ch + 1'b1;
              rd_cnt <= '0;
              state  <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sim/loop_sample_player_interp_tb.sv
// Self-checking testbench for the looping sample player with interpolation.
module loop_sample_player_interp_tb
  import lsp_pkg::*;
;

  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE_CYC  = 60;
  localparam int RAND_ITEMS  = 147;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  loop_sample_player_interp dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow state of the player
  logic signed [SAMPLE_BITS-1:0] shadow_mem [0:MEM_WORDS-1];
  bit written [0:MEM_WORDS-1];
  int unsigned reg_loop_start, reg_loop_end, reg_start_pos, reg_mode, reg_frames;
  longint play_pos;
  bit prev_gate, thru_mode, done_flag;
  int last_idx, last_nf;

  out_beat_t pending_samples[$];
  int errors = 0;
  int idle_cnt = 0;
  bit quiet = 1'b1;
  int stall_left = 0;

  typedef struct {
    in_beat_t beat;
    bit fixed;
    logic signed [SAMPLE_BITS-1:0] want0, want1;
  } dir_row_t;
  dir_row_t dir_rows[$];

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint round_sh(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic int used_frames();
    int f;
    f = reg_frames;
    if (f < 2) f = 2;
    if (f > MAX_FRAMES) f = MAX_FRAMES;
    return f;
  endfunction

  function automatic longint restart_phase();
    int s;
    s = reg_start_pos;
    if (s > used_frames() - 1) s = used_frames() - 1;
    return longint'(s) <<< FRAC_BITS;
  endfunction

  function automatic longint mem_rd(int frame, int ch);
    return longint'(shadow_mem[frame * CHANNELS + ch]);
  endfunction

  function automatic void player_reset();
    reg_loop_start = 0;
    reg_loop_end = 16383;
    reg_start_pos = 0;
    reg_mode = MODE_NONE;
    reg_frames = MAX_FRAMES;
    prev_gate = 0;
    thru_mode = 0;
    done_flag = 0;
    play_pos = restart_phase();
  endfunction

  // Advance the shadow player by one beat and queue the samples it yields;
  // a dry pass only finds the read frame and leaves the player untouched
  function automatic void predict_samples(in_beat_t b, bit dry = 1'b0);
    longint rt, lo, hi, len, p, r, fr, y0, y1, y2, y3, c1, c2, c3, t, v;
    int nf, s, e, tmp, idx;
    out_beat_t o;
    longint sv_pos;
    bit sv_pg, sv_tm, sv_df;
    if (b.cmd == CMD_WRITE) begin
      if (dry) return;
      shadow_mem[b.write_frame * CHANNELS + b.write_channel] = b.write_value;
      written[b.write_frame * CHANNELS + b.write_channel] = 1'b1;
      return;
    end
    sv_pos = play_pos;
    sv_pg = prev_gate;
    sv_tm = thru_mode;
    sv_df = done_flag;
    rt = longint'(b.rate);
    nf = used_frames();
    s = (reg_loop_start < nf - 1) ? reg_loop_start : nf - 1;
    e = (reg_loop_end < nf - 1) ? reg_loop_end : nf - 1;
    if (s > e) begin
      tmp = s; s = e; e = tmp;
    end
    if (s == e) begin
      if (e >= nf - 1) s = e - 1;
      else e = s + 1;
    end
    if (b.gate && !prev_gate) begin
      done_flag = 0;
      thru_mode = 0;
      play_pos = restart_phase();
    end else if (!b.gate && prev_gate) begin
      thru_mode = 1;
    end
    prev_gate = b.gate;
    lo = longint'(s) <<< FRAC_BITS;
    hi = longint'(e) <<< FRAC_BITS;
    len = longint'(e - s) <<< FRAC_BITS;
    p = play_pos;
    // Wrap inside the loop, or clamp at the buffer edge in play-through
    if (rt >= 0) begin
      if (thru_mode) hi = longint'(nf) <<< FRAC_BITS;
      if (p > hi) begin
        if (thru_mode) begin
          done_flag = 1; p = hi;
        end else begin
          p -= len;
          if (p > hi) p = lo + (p - lo) % len;
        end
      end
    end else begin
      if (thru_mode) lo = 0;
      if (p < lo) begin
        if (thru_mode) begin
          done_flag = 1; p = lo;
        end else begin
          p += len;
          if (p < lo) p = hi - (hi - p) % len;
        end
      end
    end
    r = p;
    if (r < 0) r = 0;
    if (r > (longint'(nf - 1) <<< FRAC_BITS)) r = longint'(nf - 1) <<< FRAC_BITS;
    idx = int'(r >>> FRAC_BITS);
    fr = r & ((64'sd1 <<< FRAC_BITS) - 1);
    last_idx = idx;
    last_nf = nf;
    if (dry) begin
      play_pos = sv_pos;
      prev_gate = sv_pg;
      thru_mode = sv_tm;
      done_flag = sv_df;
      return;
    end
    for (int ch = 0; ch < CHANNELS; ch++) begin
      y1 = mem_rd(idx, ch);
      v = y1;
      if (reg_mode == MODE_LINEAR) begin
        y2 = mem_rd((idx + 1) % nf, ch);
        v = y1 + round_sh((y2 - y1) * fr, FRAC_BITS);
      end else if (reg_mode == MODE_CUBIC) begin
        y0 = mem_rd((idx + nf - 1) % nf, ch);
        y2 = mem_rd((idx + 1) % nf, ch);
        y3 = mem_rd((idx + 2) % nf, ch);
        c1 = y2 - y0;
        c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
        c3 = y3 - y0 + 3 * (y1 - y2);
        t = round_sh(c3 * fr, FRAC_BITS) + c2;
        t = round_sh(t * fr, FRAC_BITS) + c1;
        t = round_sh(t * fr, FRAC_BITS);
        v = y1 + round_sh(t, 1);
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      o.sample_out = v[SAMPLE_BITS-1:0];
      o.channel = ch[CH_BITS-1:0];
      o.last = (ch == CHANNELS - 1);
      o.done_res = done_flag;
      pending_samples.push_back(o);
    end
    play_pos = p + rt;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one beat and hold it until accepted; call at a rising edge
  task automatic drive_beat(in_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predict_samples(b);
  endtask

  // Wait for the block to drain, then write all registers
  task automatic load_config(int ls, int le, int sp, int md, int nf);
    int vals[5];
    vals = '{ls, le, sp, md, nf};
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_BITS-1:0];
      cfg_data <= vals[i][CFG_DATA_BITS-1:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    reg_loop_start = ls;
    reg_loop_end = le;
    reg_start_pos = sp;
    reg_mode = md & 3;
    reg_frames = nf;
  endtask

  function automatic int rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 32767;
    if (r < 4) return -32768;
    return $signed($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic in_beat_t wr_beat(int frame, int ch, int val);
    in_beat_t b;
    b = '0;
    b.cmd = CMD_WRITE;
    b.write_frame = frame[FRAME_BITS-1:0];
    b.write_channel = ch[CH_BITS-1:0];
    b.write_value = val[SAMPLE_BITS-1:0];
    b.rate = RATE_BITS'($urandom);
    b.gate = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic in_beat_t tick_beat(int rate, bit g);
    in_beat_t b;
    b = '0;
    b.cmd = CMD_TICK;
    b.write_frame = FRAME_BITS'($urandom);
    b.write_channel = CH_BITS'($urandom_range(0, 1));
    b.write_value = SAMPLE_BITS'($urandom);
    b.rate = rate[RATE_BITS-1:0];
    b.gate = g;
    return b;
  endfunction

  function automatic void add_wr(int frame, int ch, int val);
    dir_rows.push_back('{wr_beat(frame, ch, val), 1'b0, '0, '0});
  endfunction

  function automatic void add_tick(int rate, bit g, bit fixed, int w0 = 0, int w1 = 0);
    dir_rows.push_back('{tick_beat(rate, g), fixed, w0[15:0], w1[15:0]});
  endfunction

  // Directed rows over a four-frame buffer with a whole-buffer loop
  function automatic void build_directed();
    add_wr(0, 0, 32767);  add_wr(0, 1, -32768);
    add_wr(1, 0, 0);      add_wr(1, 1, 0);
    add_wr(2, 0, 1000);   add_wr(2, 1, -1000);
    add_wr(3, 0, -5);     add_wr(3, 1, 5);
    add_tick(0, 1, 1, 32767, -32768);
    add_tick(32'h10000, 1, 1, 32767, -32768);
    add_tick(32'h10000, 1, 1, 0, 0);
    add_tick(32'h10000, 1, 1, 1000, -1000);
    add_tick(32'h10000, 1, 1, -5, 5);
    add_tick(32'h8000, 1, 1, 0, 0);
    add_tick(0, 1, 1, 0, 0);
    add_tick(32'h7FFFFF, 1, 0);
    add_tick(-32'sh800000, 0, 0);
    add_tick(0, 0, 0);
    add_tick(-1, 0, 0);
    add_tick(32'h10000, 0, 0);
    add_tick(32'h30000, 0, 0);
    add_tick(0, 1, 1, 32767, -32768);
    add_wr(16383, 1, 32767);
    add_wr(16383, 0, -32768);
  endfunction

  function automatic in_beat_t random_beat(ref bit g);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return wr_beat($urandom, $urandom_range(0, 1), rand_sample());
    if ($urandom_range(0, 99) < 5) g = ~g;
    r = $urandom_range(0, 99);
    if (r < 60) return tick_beat($urandom_range(0, 6 << 16) - (3 << 16), g);
    if (r < 85) return tick_beat($urandom_range(0, 1 << 17) - (1 << 16), g);
    return tick_beat($urandom, g);
  endfunction

  // Write every word the next tick reads that holds no sample yet
  task automatic fill_reads(in_beat_t b, ref int sent);
    int fr;
    predict_samples(b, 1'b1);
    for (int k = -1; k < 3; k++) begin
      fr = (last_idx + last_nf + k) % last_nf;
      for (int c = 0; c < CHANNELS; c++) begin
        if (!written[fr * CHANNELS + c]) begin
          drive_beat(wr_beat(fr, c, rand_sample()));
          sent++;
        end
      end
    end
  endtask

  // Output stall: mostly free, some single stalls, rare long bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) out_stall <= 1'b0;
      else if (r < 96) out_stall <= 1'b1;
      else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(5, 40);
      end
    end
  end

  // Compare each output beat with the oldest predicted sample; watchdog
  always @(negedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report("output beat with no sample expected");
      end else begin
        want = pending_samples.pop_front();
        if (out_data.sample_out !== want.sample_out)
          report($sformatf("sample_out got %0d want %0d",
                           out_data.sample_out, want.sample_out));
        if (out_data.channel !== want.channel)
          report($sformatf("channel got %0d want %0d", out_data.channel, want.channel));
        if (out_data.last !== want.last)
          report($sformatf("last got %0d want %0d", out_data.last, want.last));
        if (out_data.done_res !== want.done_res)
          report($sformatf("done_res got %0d want %0d", out_data.done_res, want.done_res));
      end
    end
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("loop_sample_player_interp: mismatch");
      $finish;
    end
  end

  initial begin
    bit g;
    int cfgs[8][5];
    int n;
    in_beat_t b;
    dir_row_t row;
    cfgs = '{
      '{5, 300, 10, MODE_LINEAR, 16384},
      '{16383, 0, 16383, MODE_CUBIC, 16384},
      '{0, 0, 0, MODE_CUBIC, 2},
      '{100, 100, 100, 3, 200},
      '{16383, 16383, 16383, MODE_LINEAR, 0},
      '{40, 20, 30, MODE_CUBIC, 32767},
      '{7, 9, 8, MODE_NONE, 1},
      '{2, 60, 16383, MODE_LINEAR, 64}
    };
    player_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows
    quiet = 1'b0;
    load_config(0, 3, 0, MODE_NONE, 4);
    build_directed();
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      drive_beat(row.beat);
      if (row.fixed) begin
        pending_samples[pending_samples.size() - 2].sample_out = row.want0;
        pending_samples[pending_samples.size() - 1].sample_out = row.want1;
      end
    end
    g = prev_gate;

    // Random phases across register settings; unread words are written first
    for (int ph = 0; ph < 8; ph++) begin
      load_config(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3], cfgs[ph][4]);
      quiet = (ph == 2);
      n = 0;
      while (n < RAND_ITEMS) begin
        b = random_beat(g);
        if (b.cmd == CMD_TICK) fill_reads(b, n);
        drive_beat(b);
        n++;
      end
    end

    in_valid <= 1'b0;
    quiet = 1'b1;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("loop_sample_player_interp: match");
    end else begin
      $display("loop_sample_player_interp: mismatch");
    end
    $finish;
  end

endmodule
